// File: hw/rtl/tfe_pkg.sv
// Shared types and constants for the timed fade entry table.
// No dependencies.
`default_nettype none
package tfe_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_TICK  = 2'd1,
        OP_STRIP = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    localparam logic [1:0] ST_ADDED   = 2'd0;
    localparam logic [1:0] ST_EVICTED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_LIVE    = 2'd3;

    localparam logic [31:0] BUMP_CEILING = 32'(1000 * 60 * 60 * 24);
    localparam logic [15:0] FULL_LEVEL   = 16'hFFFF;
    localparam logic [5:0]  MAX_RESET    = 6'd32;

    typedef struct packed {
        t_op         op;
        logic [31:0] now_ms;
        logic [31:0] fade_start_ms;
        logic [31:0] end_ms;
        logic [15:0] item_key;
    } t_cmd;

    typedef struct packed {
        logic [15:0] key;
        logic [31:0] fade_start;
        logic [31:0] end_ms;
    } t_entry;

endpackage
`default_nettype wire

// File: hw/rtl/tfe_front.sv
// Input side: accepts items, decodes the operation and queues commands.
// Depends on tfe_pkg.
`default_nettype none
module tfe_front
    import tfe_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [1:0]   i_op,
    input  wire logic [111:0] i_data,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  wire logic         i_cmd_pop
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       cmd;

    always_comb begin
        cmd.op            = t_op'(i_op);
        cmd.now_ms        = i_data[31:0];
        cmd.fade_start_ms = i_data[63:32];
        cmd.end_ms        = i_data[95:64];
        cmd.item_key      = i_data[111:96];
    end

    assign o_ready     = (r_cnt != 2'd2);
    // drop unused operation codes here
    assign push        = i_valid && o_ready && (t_op'(i_op) != OP_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/tfe_engine.sv
// Back side: entry memory, eviction scan, compaction, fade divider, result register.
// Depends on tfe_pkg.
`default_nettype none
module tfe_engine
    import tfe_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int LOOK_LIMIT = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [5:0]  i_cfg_wr_data,
    input  wire logic        i_cmd_valid,
    input  wire t_cmd        i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [15:0]      o_key,
    output logic [15:0]      o_level,
    output logic [1:0]       o_status,
    output logic             o_last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_EV_RD, S_EV_EVAL, S_SH_RD, S_SH_WR, S_ADD_WR, S_RES,
        S_SC_RD, S_SC_EVAL, S_DIV, S_SC_PUSH, S_FLUSH
    } t_state;

    t_entry        mem [CAPACITY];
    t_entry        r_rd;
    t_state        r_state;
    t_cmd          r_cmd;
    logic [5:0]    r_max;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_w;
    logic [CW-1:0] r_pick;
    logic [31:0]   r_best;
    logic          r_found;
    logic          r_evict;
    logic [47:0]   r_num;
    logic [31:0]   r_den;
    logic [31:0]   r_rem;
    logic [15:0]   r_q;
    logic [5:0]    r_bits;
    logic [15:0]   r_lvl;
    logic          r_hp;
    logic [15:0]   r_pkey;
    logic [15:0]   r_plvl;
    logic [1:0]    r_pst;
    logic          r_ov;

    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;
    logic [CW-1:0] i_nxt;
    logic          out_free;
    logic          out_load;
    logic [32:0]   div_t;
    logic [32:0]   div_s;
    logic [31:0]   remain;

    assign i_nxt    = r_i + 1'b1;
    assign out_free = !r_ov || i_ready;
    assign out_load = out_free && ((r_state == S_RES) || (r_state == S_FLUSH) ||
                                   (r_state == S_SC_PUSH && r_hp));
    assign div_t    = {r_rem, r_num[47]};
    assign div_s    = div_t - {1'b0, r_den};
    assign remain   = r_rd.end_ms - r_cmd.now_ms;
    assign o_valid  = r_ov;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_w[IW-1:0];
        mem_wd = r_rd;
        mem_re = 1'b0;
        mem_ra = r_i[IW-1:0];
        unique case (r_state)
            S_EV_RD:   mem_re = 1'b1;
            S_SC_RD:   mem_re = 1'b1;
            S_SH_RD: begin
                mem_re = 1'b1;
                mem_ra = i_nxt[IW-1:0];
            end
            S_SH_WR: begin
                mem_we = 1'b1;
                mem_wa = r_i[IW-1:0];
            end
            S_ADD_WR: begin
                mem_we = (32'(r_cnt) < 32'(CAPACITY));
                mem_wa = r_cnt[IW-1:0];
                mem_wd = '{key: r_cmd.item_key, fade_start: r_cmd.fade_start_ms,
                           end_ms: r_cmd.end_ms};
            end
            S_SC_EVAL: begin
                if (r_cmd.op == OP_STRIP) begin
                    mem_we = (r_rd.key != r_cmd.item_key);
                end else begin
                    mem_we = (r_cmd.now_ms < r_rd.end_ms);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= MAX_RESET;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_hp    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_i     <= '0;
                        r_w     <= '0;
                        r_hp    <= 1'b0;
                        r_evict <= 1'b0;
                        r_found <= 1'b0;
                        r_best  <= BUMP_CEILING;
                        if (i_cmd.op == OP_ADD) begin
                            if (r_max == 6'd0) begin
                                r_pkey  <= i_cmd.item_key;
                                r_plvl  <= 16'd0;
                                r_pst   <= ST_DROPPED;
                                r_state <= S_RES;
                            end else if (8'(r_cnt) >= 8'(r_max)) begin
                                r_state <= S_EV_RD;
                            end else begin
                                r_state <= S_ADD_WR;
                            end
                        end else begin
                            r_state <= S_SC_RD;
                        end
                    end
                end
                S_EV_RD: begin
                    if (r_i < r_cnt && 32'(r_i) < 32'(LOOK_LIMIT)) begin
                        r_state <= S_EV_EVAL;
                    end else if (r_found && r_best != 32'd0) begin
                        r_i     <= r_pick;
                        r_state <= S_SH_RD;
                    end else begin
                        r_state <= S_ADD_WR;
                    end
                end
                S_EV_EVAL: begin
                    if (r_rd.end_ms < r_best) begin
                        r_best  <= r_rd.end_ms;
                        r_pick  <= r_i;
                        r_found <= 1'b1;
                    end
                    r_i     <= i_nxt;
                    r_state <= S_EV_RD;
                end
                S_SH_RD: begin
                    if (i_nxt < r_cnt) begin
                        r_state <= S_SH_WR;
                    end else begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_evict <= 1'b1;
                        r_state <= S_ADD_WR;
                    end
                end
                S_SH_WR: begin
                    r_i     <= i_nxt;
                    r_state <= S_SH_RD;
                end
                S_ADD_WR: begin
                    r_pkey <= r_cmd.item_key;
                    if (32'(r_cnt) >= 32'(CAPACITY)) begin
                        r_plvl <= 16'd0;
                        r_pst  <= ST_DROPPED;
                    end else begin
                        r_cnt  <= r_cnt + 1'b1;
                        r_plvl <= FULL_LEVEL;
                        r_pst  <= r_evict ? ST_EVICTED : ST_ADDED;
                    end
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (out_free) begin
                        o_key    <= r_pkey;
                        o_level  <= r_plvl;
                        o_status <= r_pst;
                        o_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_SC_RD: begin
                    if (r_i < r_cnt) begin
                        r_state <= S_SC_EVAL;
                    end else begin
                        r_cnt   <= r_w;
                        r_state <= (r_hp && r_cmd.op == OP_TICK) ? S_FLUSH : S_IDLE;
                    end
                end
                S_SC_EVAL: begin
                    r_i <= i_nxt;
                    if (mem_we) begin
                        r_w <= r_w + 1'b1;
                    end
                    if (r_cmd.op == OP_TICK && mem_we) begin
                        if (r_cmd.now_ms < r_rd.fade_start) begin
                            r_lvl   <= FULL_LEVEL;
                            r_state <= S_SC_PUSH;
                        end else begin
                            r_num   <= {remain, 16'd0} - {16'd0, remain};
                            r_rem   <= 32'd0;
                            r_den   <= r_rd.end_ms - r_rd.fade_start;
                            r_bits  <= 6'd0;
                            r_state <= S_DIV;
                        end
                    end else begin
                        r_state <= S_SC_RD;
                    end
                end
                S_DIV: begin
                    r_num <= {r_num[46:0], 1'b0};
                    if (!div_s[32]) begin
                        r_rem <= div_s[31:0];
                    end else begin
                        r_rem <= div_t[31:0];
                    end
                    r_q <= {r_q[14:0], !div_s[32]};
                    r_bits <= r_bits + 1'b1;
                    if (r_bits == 6'd47) begin
                        r_lvl   <= {r_q[14:0], !div_s[32]};
                        r_state <= S_SC_PUSH;
                    end
                end
                S_SC_PUSH: begin
                    if (!r_hp || out_free) begin
                        if (r_hp) begin
                            o_key    <= r_pkey;
                            o_level  <= r_plvl;
                            o_status <= ST_LIVE;
                            o_last   <= 1'b0;
                        end
                        r_hp    <= 1'b1;
                        r_pkey  <= r_rd.key;
                        r_plvl  <= r_lvl;
                        r_state <= S_SC_RD;
                    end
                end
                S_FLUSH: begin
                    if (out_free) begin
                        o_key    <= r_pkey;
                        o_level  <= r_plvl;
                        o_status <= ST_LIVE;
                        o_last   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/timed_fade_entry_table.sv
// Channel   Dir  tdata fields (low bit up)                       tuser / tlast
// s_axis    in   now_ms, fade_start_ms, end_ms, item_key (112b)  tuser: operation
// m_axis    out  out_key, fade_level (32b)                       tuser: status, tlast: last
// cfg       in   max_entries (6b), written when i_cfg_wr_en is high
//
// One item at a time in the table engine; a two-deep queue keeps input flowing.
// Add: scans up to LOOK_LIMIT entries for the eviction pick, then shifts entries down on eviction.
// Tick: reads each entry, runs each fading survivor through a 48-step bit-serial
// divider and a push, and pushes each other survivor directly.
// Strip: reads each entry once. Synchronous active-low reset; output stalls hold the engine.
// Depends on tfe_pkg, tfe_front, tfe_engine.
`default_nettype none
module timed_fade_entry_table
    import tfe_pkg::*;
#(
    parameter int CAPACITY   = 32,
    parameter int LOOK_LIMIT = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_wr_en,
    input  wire logic [5:0]   i_cfg_wr_data,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [111:0] i_s_axis_tdata,  // now_ms, fade_start_ms, end_ms, item_key
    input  wire logic [1:0]   i_s_axis_tuser,  // operation
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,  // out_key, fade_level
    output logic [1:0]        o_m_axis_tuser,  // status
    output logic              o_m_axis_tlast
);

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    tfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tuser),
        .i_data      (i_s_axis_tdata),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    tfe_engine #(
        .CAPACITY   (CAPACITY),
        .LOOK_LIMIT (LOOK_LIMIT)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_m_axis_tvalid),
        .i_ready       (i_m_axis_tready),
        .o_key         (o_m_axis_tdata[15:0]),
        .o_level       (o_m_axis_tdata[31:16]),
        .o_status      (o_m_axis_tuser),
        .o_last        (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
// Testbench for timed_fade_entry_table: random and directed add/tick/strip items,
// predicted results compared in order. Depends on tfe_pkg and the table RTL.
`timescale 1ns / 1ps
module tb_top;
    import tfe_pkg::*;

    typedef struct {
        t_op         op;
        logic [31:0] now_ms;
        logic [31:0] fade_start_ms;
        logic [31:0] end_ms;
        logic [15:0] item_key;
    } t_item;

    typedef struct {
        logic [15:0] key;
        logic [15:0] level;
        logic [1:0]  status;
        logic        last;
    } t_report;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [5:0]   i_cfg_wr_data;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [111:0] i_s_axis_tdata;
    logic [1:0]   i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [31:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;
    logic         o_m_axis_tlast;

    timed_fade_entry_table i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tuser(o_m_axis_tuser),
        .o_m_axis_tlast(o_m_axis_tlast)
    );

    t_item       pending_items[$];
    t_report     expected_reports[$];
    logic [15:0] tbl_key[32];
    logic [31:0] tbl_fade[32];
    logic [31:0] tbl_end[32];
    int unsigned tbl_count;
    logic [5:0]  limit_reg;
    int          mismatches;
    int          cycles;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    bit          hold_req;
    t_item       cur;
    logic        o_s_axis_tready_q;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void queue_item(t_item it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void push_report(logic [15:0] k, logic [15:0] l, logic [1:0] s,
                                        logic t);
        t_report r;
        r.key = k;
        r.level = l;
        r.status = s;
        r.last = t;
        expected_reports = {expected_reports, r};
    endfunction

    function automatic void drop_slot(int unsigned pos);
        for (int unsigned i = pos; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i + 1];
            tbl_fade[i] = tbl_fade[i + 1];
            tbl_end[i] = tbl_end[i + 1];
        end
        tbl_count--;
    endfunction

    function automatic void apply_item(t_item it);
        logic [31:0] soonest;
        int unsigned pick;
        int unsigned w;
        int unsigned n;
        bit          found;
        bit          evicted;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        logic [15:0] lvl;
        soonest = BUMP_CEILING;
        pick = 0;
        w = 0;
        n = 0;
        found = 0;
        evicted = 0;
        case (it.op)
            OP_ADD: begin
                if (limit_reg == 0) begin
                    push_report(it.item_key, 16'd0, ST_DROPPED, 1'b1);
                end else begin
                    if (tbl_count >= limit_reg) begin
                        for (int unsigned i = 0; i < tbl_count; i++) begin
                            if (tbl_end[i] < soonest) begin
                                soonest = tbl_end[i];
                                pick = i;
                                found = 1;
                            end
                        end
                        if (found && soonest != 0) begin
                            drop_slot(pick);
                            evicted = 1;
                        end
                    end
                    if (tbl_count >= 32) begin
                        push_report(it.item_key, 16'd0, ST_DROPPED, 1'b1);
                    end else begin
                        tbl_key[tbl_count] = it.item_key;
                        tbl_fade[tbl_count] = it.fade_start_ms;
                        tbl_end[tbl_count] = it.end_ms;
                        tbl_count++;
                        push_report(it.item_key, FULL_LEVEL,
                                    evicted ? ST_EVICTED : ST_ADDED, 1'b1);
                    end
                end
            end
            OP_TICK: begin
                for (int unsigned i = 0; i < tbl_count; i++) begin
                    if (it.now_ms < tbl_end[i]) begin
                        if (it.now_ms >= tbl_fade[i]) begin
                            num = 64'(32'(tbl_end[i] - it.now_ms)) * 64'd65535;
                            den = 64'(32'(tbl_end[i] - tbl_fade[i]));
                            q = (den == 0) ? 64'd0 : num / den;
                            lvl = (q > 64'd65535) ? FULL_LEVEL : q[15:0];
                        end else begin
                            lvl = FULL_LEVEL;
                        end
                        tbl_key[w] = tbl_key[i];
                        tbl_fade[w] = tbl_fade[i];
                        tbl_end[w] = tbl_end[i];
                        w++;
                        push_report(tbl_key[i], lvl, ST_LIVE, 1'b0);
                        n++;
                    end
                end
                tbl_count = w;
                if (n > 0)
                    expected_reports[$].last = 1'b1;
            end
            OP_STRIP: begin
                for (int unsigned i = 0; i < tbl_count; i++) begin
                    if (tbl_key[i] != it.item_key) begin
                        tbl_key[w] = tbl_key[i];
                        tbl_fade[w] = tbl_fade[i];
                        tbl_end[w] = tbl_end[i];
                        w++;
                    end
                end
                tbl_count = w;
            end
            default: ;
        endcase
    endfunction

    function automatic t_item make_item(t_op op, logic [31:0] now, logic [31:0] fs,
                                        logic [31:0] en, logic [15:0] key);
        t_item it;
        it.op = op;
        it.now_ms = now;
        it.fade_start_ms = fs;
        it.end_ms = en;
        it.item_key = key;
        return it;
    endfunction

    function automatic logic [31:0] rand_time(logic [31:0] base);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'd0;
            2: return BUMP_CEILING + $urandom_range(0, 3) - 2;
            3: return 32'hFFFF_FFFF - $urandom_range(0, 2);
            default: return base + $urandom_range(0, 3000);
        endcase
    endfunction

    function automatic t_item rand_item(logic [31:0] clock_ms);
        int          sel;
        logic [31:0] fs;
        sel = $urandom_range(0, 99);
        fs = rand_time(clock_ms);
        if (sel < 55)
            return make_item(OP_ADD, $urandom, fs,
                             ($urandom_range(0, 3) == 0) ? rand_time(clock_ms)
                                                          : fs + $urandom_range(0, 4000),
                             16'($urandom_range(0, 15)) | ($urandom_range(0, 9) == 0 ?
                                                           16'($urandom) : 16'd0));
        if (sel < 85)
            return make_item(OP_TICK, rand_time(clock_ms), $urandom, $urandom, $urandom);
        if (sel < 96)
            return make_item(OP_STRIP, $urandom, $urandom, $urandom,
                             16'($urandom_range(0, 15)));
        return make_item(OP_NONE, $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || expected_reports.size() != 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (2500) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [5:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_reg = v;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            apply_item(cur);
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready_q) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                cur = pending_items.pop_front();
                i_s_axis_tdata <= {cur.item_key, cur.end_ms, cur.fade_start_ms, cur.now_ms};
                i_s_axis_tuser <= cur.op;
                i_s_axis_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk)
        o_s_axis_tready_q <= i_s_axis_tvalid && o_s_axis_tready;

    // monitor
    always @(posedge i_clk) begin
        t_report e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item key=%h level=%h status=%0d last=%b",
                             o_m_axis_tdata[15:0], o_m_axis_tdata[31:16],
                             o_m_axis_tuser, o_m_axis_tlast);
            end else begin
                e = expected_reports.pop_front();
                if (o_m_axis_tdata[15:0] !== e.key || o_m_axis_tdata[31:16] !== e.level ||
                    o_m_axis_tuser !== e.status || o_m_axis_tlast !== e.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp key=%h lvl=%h st=%0d last=%b got key=%h lvl=%h st=%0d last=%b",
                                 e.key, e.level, e.status, e.last,
                                 o_m_axis_tdata[15:0], o_m_axis_tdata[31:16],
                                 o_m_axis_tuser, o_m_axis_tlast);
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && hold_left == 0 && i_rst_n) begin
            hold_left <= 3000;
            hold_req <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (cycles % 2048 < 700) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 10000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [31:0] clock_ms;
        logic [5:0]  limits[5];
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = '0;
        i_m_axis_tready = 1'b0;
        o_s_axis_tready_q = 1'b0;
        cycles = 0;
        mismatches = 0;
        burst_left = 0;
        gap_left = 0;
        hold_left = 0;
        hold_req = 1'b0;
        tbl_count = 0;
        limit_reg = MAX_RESET;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, eviction, zero end, full table, fades, strip, unused op
        queue_item(make_item(OP_ADD, 0, 100, 200, 16'hFFFF));
        queue_item(make_item(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 16'h0000));
        queue_item(make_item(OP_ADD, 0, 0, 0, 16'h0001));
        queue_item(make_item(OP_ADD, 0, 50, 50, 16'h0002));
        queue_item(make_item(OP_ADD, 0, 300, 100, 16'h0003));
        queue_item(make_item(OP_TICK, 10, 0, 0, 0));
        queue_item(make_item(OP_TICK, 150, 0, 0, 0));
        queue_item(make_item(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 16'hFFFF));
        queue_item(make_item(OP_STRIP, 0, 0, 0, 16'hFFFF));
        queue_item(make_item(OP_TICK, 32'hFFFF_FFFE, 0, 0, 0));
        queue_item(make_item(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0));
        queue_item(make_item(OP_TICK, 0, 0, 0, 0));
        wait_idle();

        write_limit(6'd2);
        queue_item(make_item(OP_ADD, 0, 0, BUMP_CEILING, 16'h0010));
        queue_item(make_item(OP_ADD, 0, 0, BUMP_CEILING - 1, 16'h0011));
        queue_item(make_item(OP_ADD, 0, 0, 500, 16'h0012));
        queue_item(make_item(OP_ADD, 0, 0, 0, 16'h0013));
        queue_item(make_item(OP_TICK, 0, 0, 0, 0));
        queue_item(make_item(OP_STRIP, 0, 0, 0, 16'h0013));
        wait_idle();
        write_limit(6'd0);
        queue_item(make_item(OP_ADD, 0, 1, 2, 16'h5A5A));
        queue_item(make_item(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0));
        wait_idle();

        // long hold-off while a full table is ticked
        write_limit(6'd63);
        for (int i = 0; i < 34; i++)
            queue_item(make_item(OP_ADD, 0, 1000, BUMP_CEILING + 5, 16'(i)));
        queue_item(make_item(OP_TICK, 10, 0, 0, 0));
        queue_item(make_item(OP_TICK, 2000, 0, 0, 0));
        hold_req = 1'b1;
        wait_idle();
        queue_item(make_item(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0));
        wait_idle();

        limits[0] = 6'd1;
        limits[1] = 6'd32;
        limits[2] = 6'd5;
        limits[3] = 6'd63;
        limits[4] = 6'd16;
        clock_ms = $urandom;
        for (int ph = 0; ph < 5; ph++) begin
            write_limit(limits[ph]);
            for (int i = 0; i < 82; i++) begin
                queue_item(rand_item(clock_ms));
                clock_ms += $urandom_range(0, 400);
            end
            queue_item(make_item(OP_TICK, 32'hFFFF_FFFF, 0, 0, 0));
            wait_idle();
        end

        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: timed_fade_entry_table.f
hw/rtl/tfe_pkg.sv
hw/rtl/tfe_front.sv
hw/rtl/tfe_engine.sv
hw/rtl/timed_fade_entry_table.sv
tb/sv/tb_top.sv
